@@ rtl/core/round_robin_slot_scheduler_drain_core_macros.svh @@
// Assertion helpers for the slot scheduler core.
// The macros sample on the rising edge of clock and are off while reset is high.
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_DRAIN_CORE_MACROS_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_DRAIN_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define RRSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
// Next-cycle implication.
`define RRSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define RRSD_ASSERT_NOW(label, ante, cons)
`define RRSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/rrsd_pkg.sv @@
`default_nettype none
package rrsd_pkg;

   // Field widths
   localparam int KIND_W     = 2;
   localparam int DEV_W      = 2;
   localparam int PORT_W     = 3;
   localparam int LEVEL_W    = 8;
   localparam int TIME_W     = 48;
   localparam int CHAN_W     = 8;
   localparam int MASK_W     = 3;
   localparam int OUT_CHANS  = 6;
   localparam int DRAIN_W    = 2;

   // Stream widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int INTERVAL_W = 20;
   localparam int GRACE_W    = 2;
   localparam int ELIG_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE_SERVICES     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELIGIBLE_DEVICES   = 2'd2;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd25000;
   localparam logic [GRACE_W-1:0]    GRACE_RST    = 2'd3;
   localparam logic [ELIG_W-1:0]     ELIG_RST     = 2'd2;

   // Defaults for the top-level parameters
   localparam int DEV_COUNT_DEF    = 3;
   localparam int NUM_CHANNELS_DEF = 6;

   localparam logic [CHAN_W-1:0] NEUTRAL = 8'h80;

   // Input item kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OFF   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ON    = 2'd3;

   // Result kinds
   localparam logic [KIND_W-1:0] SEND_PERIODIC = 2'd0;
   localparam logic [KIND_W-1:0] SEND_EVENT    = 2'd1;
   localparam logic [KIND_W-1:0] SEND_CONNECT  = 2'd2;

   typedef struct packed {
      logic             found;
      logic [DEV_W-1:0] dev;
   } pick_type;

endpackage
`default_nettype wire

@@ rtl/core/rrsd_row_mem.sv @@
`default_nettype none
module rrsd_row_mem
   import rrsd_pkg::*;
#(
   parameter int              WIDTH   = 48,
   parameter int              DEPTH   = DEV_COUNT_DEF,
   parameter logic [WIDTH-1:0] RST_ROW = '0
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data,
   input  wire                                       wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                          wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] q_ff;
   logic             qv_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   // A row never written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         qv_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            qv_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = qv_ff ? q_ff : RST_ROW;

endmodule
`default_nettype wire

@@ rtl/core/rrsd_rr_pick.sv @@
`default_nettype none
module rrsd_rr_pick
   import rrsd_pkg::*;
#(
   parameter int DEV_COUNT = DEV_COUNT_DEF
) (
   input  wire  [DEV_COUNT-1:0] active,
   input  wire  [DEV_W-1:0]     last,
   output pick_type             pick
);

   localparam int AW = (DEV_COUNT > 1) ? $clog2(DEV_COUNT) : 1;
   localparam logic [DEV_W-1:0] TOP_DEV = DEV_W'(DEV_COUNT - 1);

   logic [DEV_W-1:0] idx;

   // Walk forward from the last served device, wrapping at the top
   always_comb begin
      idx  = last;
      pick = '0;
      for (int i = 0; i < DEV_COUNT; i++) begin
         if (idx == TOP_DEV) begin
            idx = '0;
         end else begin
            idx = idx + 1'b1;
         end
         if (!pick.found && active[idx[AW-1:0]]) begin
            pick.found = 1'b1;
            pick.dev   = idx;
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/round_robin_slot_scheduler_drain_core.sv @@
// Round-robin slot scheduler with drain for up to three devices of six byte channels.
// Input stream req_*: one command per transfer (tick, channel write, toggle off/on),
//    command kind in req_tuser. Result stream rsp_*: zero, one or two results per
//    command; rsp_tlast marks the final result of a command.
// Configuration port csr_*: ready whenever reset is low; write only while no command is in flight.
// Flow: a command is taken in ST_IDLE while the device row and its event timestamp are
//    read from memory, ST_EXEC updates and writes them back, and the first result is
//    valid in ST_SEND. A second result follows on the cycle after the first transfer.
// Throughput: one command at a time; a command without result returns from ST_EXEC to
//    ST_IDLE, otherwise it stays in ST_SEND until its final result is taken.
//    req_tready is low from acceptance until the final result is taken.
// Stall: with rsp_tready low the result holds on rsp_tdata and no command is taken.
// Reset: synchronous, active high. Registers return to their reset values, channel rows
//    read as neutral and timestamps as zero until first written; no clearing pass.
`default_nettype none
`include "round_robin_slot_scheduler_drain_core_macros.svh"
module round_robin_slot_scheduler_drain_core
   import rrsd_pkg::*;
#(
   parameter int DEV_COUNT    = DEV_COUNT_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   // req_tdata: device[1:0], port[4:2], level[12:5], time_us[60:13], zero pad[63:61]
   input  wire  [REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: kind[1:0]
   input  wire  [KIND_W-1:0]       req_tuser,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // rsp_tdata: served_device[1:0], chan_a[9:2], chan_b[17:10], chan_c[25:18],
   //    chan_d[33:26], chan_e[41:34], chan_f[49:42], dropped[50], active_mask[53:51],
   //    zero pad[55:54]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: send_kind[1:0]
   output logic [KIND_W-1:0]       rsp_tuser,
   output logic                    rsp_tlast,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_data
);

   localparam int DEV_AW = (DEV_COUNT > 1) ? $clog2(DEV_COUNT) : 1;
   localparam int ROW_W  = NUM_CHANNELS * CHAN_W;
   localparam logic [DEV_W:0]  NDEV_L = (DEV_W + 1)'(DEV_COUNT);
   localparam logic [PORT_W:0] NCH_L  = (PORT_W + 1)'(NUM_CHANNELS);
   localparam logic [ROW_W-1:0] NEUTRAL_ROW = {NUM_CHANNELS{NEUTRAL}};

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   // Control state
   logic [1:0]             state_ff, state_in;
   logic [INTERVAL_W-1:0]  interval_ff, interval_in;
   logic [GRACE_W-1:0]     grace_ff, grace_in;
   logic [ELIG_W-1:0]      elig_ff, elig_in;
   logic [DEV_COUNT-1:0]   active_ff, active_in;
   logic [DRAIN_W-1:0]     drain_ff [DEV_COUNT];
   logic [DRAIN_W-1:0]     drain_in [DEV_COUNT];
   logic [DEV_W-1:0]       last_ff, last_in;
   logic                   second_ff, second_in;

   // Command held for the update cycle
   logic [KIND_W-1:0]      kind_ff;
   logic [DEV_W-1:0]       dev_ff;
   logic [PORT_W-1:0]      port_ff;
   logic [LEVEL_W-1:0]     level_ff;
   logic [TIME_W-1:0]      time_ff;
   pick_type               pick_ff;

   // Result register
   logic [KIND_W-1:0]      out_kind_ff, out_kind_in;
   logic                   out_last_ff, out_last_in;
   logic [DEV_W-1:0]       out_dev_ff, out_dev_in;
   logic [ROW_W-1:0]       out_row_ff, out_row_in;
   logic                   out_dropped_ff, out_dropped_in;
   logic [MASK_W-1:0]      out_mask_ff, out_mask_in;

   // Accept side
   logic                   req_fire;
   pick_type               pick;
   logic [KIND_W-1:0]      req_kind;
   logic [DEV_W-1:0]       req_dev;
   logic [DEV_W-1:0]       rd_dev;
   logic [DEV_AW-1:0]      rd_addr;

   // Update side
   logic [ROW_W-1:0]       row;
   logic [TIME_W-1:0]      prev_time;
   logic [TIME_W-1:0]      time_diff;
   logic                   rate_ok;
   logic                   dev_ok;
   logic                   port_ok;
   logic [DEV_AW-1:0]      dev_idx;
   logic [DEV_AW-1:0]      tick_idx;
   logic                   act;
   logic [DRAIN_W-1:0]     dcount;
   logic [DRAIN_W-1:0]     tick_count;
   logic [CHAN_W-1:0]      old_byte;
   logic [ROW_W-1:0]       row_written;
   logic                   neutral_changed;
   logic                   chan_we;
   logic [ROW_W-1:0]       chan_wdata;
   logic                   time_we;
   logic                   res_valid;
   logic                   res_two;
   logic [KIND_W-1:0]      res_kind;
   logic [CHAN_W-1:0]      out_chan [OUT_CHANS];

   assign req_kind   = req_tuser;
   assign req_dev    = req_tdata[1:0];
   // Take nothing while reset is high
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   rrsd_rr_pick #(
      .DEV_COUNT(DEV_COUNT)
   ) u_pick (
      .active(active_ff),
      .last  (last_ff),
      .pick  (pick)
   );

   // Out-of-range devices read row 0; their result is discarded
   always_comb begin
      rd_dev  = (req_kind == KIND_TICK) ? pick.dev : req_dev;
      rd_addr = ({1'b0, rd_dev} < NDEV_L) ? rd_dev[DEV_AW-1:0] : '0;
   end

   rrsd_row_mem #(
      .WIDTH  (ROW_W),
      .DEPTH  (DEV_COUNT),
      .RST_ROW(NEUTRAL_ROW)
   ) u_chan_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_fire),
      .rd_addr(rd_addr),
      .rd_data(row),
      .wr_en  (chan_we),
      .wr_addr(dev_idx),
      .wr_data(chan_wdata)
   );

   rrsd_row_mem #(
      .WIDTH  (TIME_W),
      .DEPTH  (DEV_COUNT),
      .RST_ROW('0)
   ) u_time_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_fire),
      .rd_addr(rd_addr),
      .rd_data(prev_time),
      .wr_en  (time_we),
      .wr_addr(dev_idx),
      .wr_data(time_ff)
   );

   // Per-command decode for the update cycle
   always_comb begin
      dev_ok     = ({1'b0, dev_ff} < NDEV_L);
      port_ok    = ({1'b0, port_ff} < NCH_L);
      dev_idx    = dev_ff[DEV_AW-1:0];
      tick_idx   = pick_ff.dev[DEV_AW-1:0];
      act        = dev_ok && active_ff[dev_idx];
      dcount     = dev_ok ? drain_ff[dev_idx] : '0;
      tick_count = drain_ff[tick_idx];
      time_diff  = time_ff - prev_time;
      rate_ok    = (time_ff >= prev_time) && (time_diff >= TIME_W'(interval_ff));
      neutral_changed = (row != NEUTRAL_ROW);
      old_byte    = NEUTRAL;
      row_written = row;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (port_ff == PORT_W'(ch)) begin
            old_byte = row[ch*CHAN_W +: CHAN_W];
            row_written[ch*CHAN_W +: CHAN_W] = level_ff;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      interval_in    = interval_ff;
      grace_in       = grace_ff;
      elig_in        = elig_ff;
      active_in      = active_ff;
      drain_in       = drain_ff;
      last_in        = last_ff;
      second_in      = second_ff;
      out_kind_in    = out_kind_ff;
      out_last_in    = out_last_ff;
      out_dev_in     = out_dev_ff;
      out_row_in     = out_row_ff;
      out_dropped_in = out_dropped_ff;
      out_mask_in    = out_mask_ff;
      chan_we        = 1'b0;
      chan_wdata     = NEUTRAL_ROW;
      time_we        = 1'b0;
      res_valid      = 1'b0;
      res_two        = 1'b0;
      res_kind       = SEND_EVENT;

      if (csr_valid) begin
         case (csr_index)
            CSR_EVENT_MIN_INTERVAL: interval_in = csr_data[INTERVAL_W-1:0];
            CSR_GRACE_SERVICES:     grace_in    = csr_data[GRACE_W-1:0];
            CSR_ELIGIBLE_DEVICES:   elig_in     = csr_data[ELIG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            out_dropped_in = 1'b0;
            out_dev_in     = dev_ff;
            case (kind_ff)
               KIND_TICK: begin
                  if (pick_ff.found) begin
                     last_in    = pick_ff.dev;
                     res_valid  = 1'b1;
                     res_kind   = SEND_PERIODIC;
                     out_dev_in = pick_ff.dev;
                     out_row_in = row;
                     if (tick_count != '0) begin
                        drain_in[tick_idx] = tick_count - 1'b1;
                        if (tick_count == DRAIN_W'(1)) begin
                           active_in[tick_idx] = 1'b0;
                           out_dropped_in      = 1'b1;
                        end
                     end
                  end
               end
               KIND_WRITE: begin
                  if (dev_ok && port_ok) begin
                     chan_we    = 1'b1;
                     chan_wdata = row_written;
                     out_row_in = row_written;
                     if ((old_byte != level_ff) && act && rate_ok) begin
                        time_we   = 1'b1;
                        res_valid = 1'b1;
                     end
                  end
               end
               KIND_OFF: begin
                  if (act && (dcount == '0)) begin
                     chan_we           = 1'b1;
                     out_row_in        = NEUTRAL_ROW;
                     drain_in[dev_idx] = (grace_ff == '0) ? DRAIN_W'(1) : grace_ff;
                     if (neutral_changed && rate_ok) begin
                        time_we   = 1'b1;
                        res_valid = 1'b1;
                     end
                  end
               end
               KIND_ON: begin
                  if (dev_ok && (dev_ff < elig_ff) && !(act && (dcount == '0))) begin
                     chan_we            = 1'b1;
                     out_row_in         = NEUTRAL_ROW;
                     drain_in[dev_idx]  = '0;
                     active_in[dev_idx] = 1'b1;
                     res_valid          = 1'b1;
                     res_kind           = SEND_CONNECT;
                     if (neutral_changed && act && rate_ok) begin
                        time_we = 1'b1;
                        res_two = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
            out_mask_in = '0;
            for (int d = 0; d < DEV_COUNT; d++) begin
               out_mask_in[d] = active_in[d];
            end
            out_kind_in = res_kind;
            out_last_in = !res_two;
            second_in   = res_two;
            state_in    = res_valid ? ST_SEND : ST_IDLE;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (second_ff) begin
                  // connect replay went out; follow with the event send
                  out_kind_in = SEND_EVENT;
                  out_last_in = 1'b1;
                  second_in   = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         interval_ff <= INTERVAL_RST;
         grace_ff    <= GRACE_RST;
         elig_ff     <= ELIG_RST;
         for (int d = 0; d < DEV_COUNT; d++) begin
            active_ff[d] <= (DEV_W'(d) < ELIG_RST);
            drain_ff[d]  <= '0;
         end
         last_ff     <= DEV_W'(DEV_COUNT - 1);
         second_ff   <= 1'b0;
         out_kind_ff <= SEND_PERIODIC;
         out_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         interval_ff <= interval_in;
         grace_ff    <= grace_in;
         elig_ff     <= elig_in;
         active_ff   <= active_in;
         drain_ff    <= drain_in;
         last_ff     <= last_in;
         second_ff   <= second_in;
         out_kind_ff <= out_kind_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= req_kind;
         dev_ff   <= req_dev;
         port_ff  <= req_tdata[4:2];
         level_ff <= req_tdata[12:5];
         time_ff  <= req_tdata[60:13];
         pick_ff  <= pick;
      end
      out_dev_ff     <= out_dev_in;
      out_row_ff     <= out_row_in;
      out_dropped_ff <= out_dropped_in;
      out_mask_ff    <= out_mask_in;
   end

   // Channels past the configured count read neutral
   for (genvar ch = 0; ch < OUT_CHANS; ch++) begin : g_out_chan
      if (ch < NUM_CHANNELS) begin : g_real
         assign out_chan[ch] = out_row_ff[ch*CHAN_W +: CHAN_W];
      end else begin : g_pad
         assign out_chan[ch] = NEUTRAL;
      end
   end

   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_mask_ff, out_dropped_ff,
                        out_chan[5], out_chan[4], out_chan[3],
                        out_chan[2], out_chan[1], out_chan[0], out_dev_ff};

   `RRSD_ASSERT_NOW(a_busy_while_sending, rsp_tvalid, !req_tready)
   `RRSD_ASSERT_NOW(a_drop_only_on_tick, rsp_tvalid && rsp_tdata[50], rsp_tuser == SEND_PERIODIC)
   `RRSD_ASSERT_NOW(a_first_of_two_is_connect, rsp_tvalid && !rsp_tlast, rsp_tuser == SEND_CONNECT)
   `RRSD_ASSERT_NEXT(a_event_follows_connect, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tlast && (rsp_tuser == SEND_EVENT))

endmodule
`default_nettype wire
